// File: hw/rtl/fast_inverse_sqrt_fp32_defines.svh
// Assertion macros for the checker file of the inverse square root block.
`ifndef FAST_INVERSE_SQRT_FP32_DEFINES_SVH
`define FAST_INVERSE_SQRT_FP32_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define FISQ_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define FISQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: hw/rtl/fisq_pkg.sv
// Constants and helper functions for the fast inverse square root pipeline.
package fisq_pkg;

  localparam logic [31:0] MAGIC_SEED   = 32'h5f3759df;
  localparam logic [31:0] ONE_HALF     = 32'h3f000000;
  localparam logic [31:0] THREE_HALVES = 32'h3fc00000;
  localparam logic [31:0] CANON_QNAN   = 32'h7fc00000;
  localparam logic [7:0]  EXP_MAX      = 8'hff;
  localparam int          SEED_DEPTH   = 12;

  typedef struct packed {
    logic nan;
    logic inf;
    logic zero;
  } fp_flags_t;

  // Leading zeros of a nonzero 23-bit fraction.
  function automatic logic [4:0] lzc23(input logic [22:0] v);
    logic [4:0] cnt;
    cnt = 5'd23;
    for (int i = 0; i < 23; i++) begin
      if (v[i]) cnt = 5'(22 - i);
    end
    return cnt;
  endfunction

  // Leading zeros of a 27-bit word, 27 when it is zero.
  function automatic logic [4:0] lzc27(input logic [26:0] v);
    logic [4:0] cnt;
    cnt = 5'd27;
    for (int i = 0; i < 27; i++) begin
      if (v[i]) cnt = 5'(26 - i);
    end
    return cnt;
  endfunction

endpackage

// File: hw/rtl/fast_inverse_sqrt_fp32.sv
// Top level of the fast inverse square root pipeline: seed, Newton step, output.
//
//  channel | ports                                      | role
//  --------+--------------------------------------------+-------------------------
//  in      | in_valid, in_stall, in_value_bits[31:0]    | binary32 operand
//  out     | out_valid, out_stall, out_result_bits[31:0]| binary32 approx 1/sqrt
//
// One item enters per cycle while no held result stalls the output.
// The datapath is five floating-point units of three stages each, chained in series.
// Reset clears only the valid bits; the pipeline then accepts an item at once.
// A stall at the output while out_valid is high freezes every stage, and in_stall follows it.
module fast_inverse_sqrt_fp32
  import fisq_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] in_value_bits,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_result_bits
);

  logic        en;
  logic [31:0] seed_nxt;
  logic [31:0] seed_r [SEED_DEPTH];
  logic        half_v, hy_v, hyy_v, sub_v;
  logic [31:0] half, hy, hyy, corr;

  assign en       = !(out_valid && out_stall);
  assign in_stall = out_valid && out_stall;

  // Arithmetic shift right by one, subtracted from the magic constant.
  assign seed_nxt = MAGIC_SEED - {in_value_bits[31], in_value_bits[31:1]};

  always_ff @(posedge clk) begin
    if (en) begin
      seed_r[0] <= seed_nxt;
      for (int i = 1; i < SEED_DEPTH; i++) begin
        seed_r[i] <= seed_r[i-1];
      end
    end
  end

  fisq_mul u_half (
    .clk, .rst_n, .en,
    .in_valid  (in_valid),
    .a         (in_value_bits),
    .b         (ONE_HALF),
    .out_valid (half_v),
    .result    (half)
  );

  fisq_mul u_hy (
    .clk, .rst_n, .en,
    .in_valid  (half_v),
    .a         (half),
    .b         (seed_r[2]),
    .out_valid (hy_v),
    .result    (hy)
  );

  fisq_mul u_hyy (
    .clk, .rst_n, .en,
    .in_valid  (hy_v),
    .a         (hy),
    .b         (seed_r[5]),
    .out_valid (hyy_v),
    .result    (hyy)
  );

  fisq_add u_sub (
    .clk, .rst_n, .en,
    .in_valid  (hyy_v),
    .a         (THREE_HALVES),
    .b         ({~hyy[31], hyy[30:0]}),
    .out_valid (sub_v),
    .result    (corr)
  );

  fisq_mul u_res (
    .clk, .rst_n, .en,
    .in_valid  (sub_v),
    .a         (seed_r[11]),
    .b         (corr),
    .out_valid (out_valid),
    .result    (out_result_bits)
  );

endmodule

// File: hw/rtl/fisq_mul.sv
// Three-stage binary32 multiplier with round to nearest even and subnormal support.
module fisq_mul
  import fisq_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        en,
  input  logic        in_valid,
  input  logic [31:0] a,
  input  logic [31:0] b,
  output logic        out_valid,
  output logic [31:0] result
);

  // Stage 1: unpack and pre-normalize subnormal operands.
  logic              a_zero, a_inf, a_nan, b_zero, b_inf, b_nan;
  logic [4:0]        lz_a, lz_b;
  logic [23:0]       ma, mb;
  logic signed [9:0] xa, xb;
  fp_flags_t         fl1_nxt;

  always_comb begin
    a_zero = (a[30:23] == 8'd0) && (a[22:0] == 23'd0);
    b_zero = (b[30:23] == 8'd0) && (b[22:0] == 23'd0);
    a_inf  = (a[30:23] == EXP_MAX) && (a[22:0] == 23'd0);
    b_inf  = (b[30:23] == EXP_MAX) && (b[22:0] == 23'd0);
    a_nan  = (a[30:23] == EXP_MAX) && (a[22:0] != 23'd0);
    b_nan  = (b[30:23] == EXP_MAX) && (b[22:0] != 23'd0);
    lz_a   = lzc23(a[22:0]);
    lz_b   = lzc23(b[22:0]);
    if (a[30:23] == 8'd0) begin
      ma = {1'b0, a[22:0]} << (lz_a + 5'd1);
      xa = -$signed({5'd0, lz_a});
    end else begin
      ma = {1'b1, a[22:0]};
      xa = $signed({2'b00, a[30:23]});
    end
    if (b[30:23] == 8'd0) begin
      mb = {1'b0, b[22:0]} << (lz_b + 5'd1);
      xb = -$signed({5'd0, lz_b});
    end else begin
      mb = {1'b1, b[22:0]};
      xb = $signed({2'b00, b[30:23]});
    end
    fl1_nxt.nan  = a_nan | b_nan | (a_inf & b_zero) | (a_zero & b_inf);
    fl1_nxt.inf  = a_inf | b_inf;
    fl1_nxt.zero = a_zero | b_zero;
  end

  logic              v1_r, v2_r, v3_r;
  logic              s1_r, s2_r;
  fp_flags_t         fl1_r, fl2_r;
  logic [23:0]       ma_r, mb_r;
  logic signed [9:0] es1_r, es2_r;
  logic [47:0]       prod_r;
  logic [31:0]       res_r, res_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_r   <= a[31] ^ b[31];
      fl1_r  <= fl1_nxt;
      ma_r   <= ma;
      mb_r   <= mb;
      es1_r  <= xa + xb - 10'sd127;
      s2_r   <= s1_r;
      fl2_r  <= fl1_r;
      es2_r  <= es1_r;
      prod_r <= ma_r * mb_r;
      res_r  <= res_nxt;
    end
  end

  // Stage 3: normalize, denormalize below the normal range, and round.
  logic [47:0]        pn, shifted, lost_mask;
  logic signed [10:0] e_res, d_sh;
  logic [5:0]         sh;
  logic               g, st, rnd;
  logic [7:0]         expf;
  logic [30:0]        mag;

  always_comb begin
    pn    = prod_r[47] ? prod_r : (prod_r << 1);
    e_res = 11'(es2_r) + $signed({10'd0, prod_r[47]});
    d_sh  = 11'sd1 - e_res;
    if (e_res >= 11'sd1) begin
      sh = 6'd0;
    end else if (d_sh > 11'sd48) begin
      sh = 6'd48;
    end else begin
      sh = d_sh[5:0];
    end
    shifted   = pn >> sh;
    lost_mask = ~({48{1'b1}} << sh);
    g    = shifted[23];
    st   = (|shifted[22:0]) | (|(pn & lost_mask));
    rnd  = g & (st | shifted[24]);
    expf = (e_res >= 11'sd1) ? e_res[7:0] : 8'd0;
    mag  = {expf, shifted[46:24]} + {30'd0, rnd};
    if (fl2_r.nan) begin
      res_nxt = CANON_QNAN;
    end else if (fl2_r.inf || e_res >= 11'sd255) begin
      res_nxt = {s2_r, EXP_MAX, 23'd0};
    end else if (fl2_r.zero) begin
      res_nxt = {s2_r, 31'd0};
    end else begin
      res_nxt = {s2_r, mag};
    end
  end

  assign out_valid = v3_r;
  assign result    = res_r;

endmodule

// File: hw/rtl/fisq_add.sv
// Three-stage binary32 adder with round to nearest even and subnormal support.
module fisq_add
  import fisq_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        en,
  input  logic        in_valid,
  input  logic [31:0] a,
  input  logic [31:0] b,
  output logic        out_valid,
  output logic [31:0] result
);

  // Stage 1: order operands by magnitude and find the alignment distance.
  logic        a_inf, a_nan, b_inf, b_nan, a_big;
  logic [31:0] big, sml;
  logic [7:0]  e_big, e_sml, e_gap;
  logic [4:0]  d_nxt;
  fp_flags_t   fl_nxt;

  always_comb begin
    a_inf = (a[30:23] == EXP_MAX) && (a[22:0] == 23'd0);
    b_inf = (b[30:23] == EXP_MAX) && (b[22:0] == 23'd0);
    a_nan = (a[30:23] == EXP_MAX) && (a[22:0] != 23'd0);
    b_nan = (b[30:23] == EXP_MAX) && (b[22:0] != 23'd0);
    a_big = a[30:0] >= b[30:0];
    big   = a_big ? a : b;
    sml   = a_big ? b : a;
    e_big = (big[30:23] == 8'd0) ? 8'd1 : big[30:23];
    e_sml = (sml[30:23] == 8'd0) ? 8'd1 : sml[30:23];
    e_gap = e_big - e_sml;
    d_nxt = (e_gap > 8'd27) ? 5'd27 : e_gap[4:0];
    fl_nxt.nan  = a_nan | b_nan | (a_inf & b_inf & (a[31] != b[31]));
    fl_nxt.inf  = a_inf | b_inf;
    fl_nxt.zero = 1'b0;
  end

  logic        v1_r, v2_r, v3_r;
  fp_flags_t   fl1_r, fl2_r;
  logic        s1_r, s2_r, sub1_r, sub2_r, is1_r, is2_r;
  logic [23:0] mbig_r, msml_r;
  logic [4:0]  d_r;
  logic [7:0]  eb1_r, eb2_r;
  logic [27:0] sum_r, sum_nxt;
  logic [31:0] res_r, res_nxt;

  // Stage 2: align the smaller operand with sticky collection, then add or subtract.
  logic [26:0] big27, sml27, sm, lost_mask;

  always_comb begin
    big27     = {mbig_r, 3'b000};
    sml27     = {msml_r, 3'b000};
    lost_mask = ~({27{1'b1}} << d_r);
    sm        = sml27 >> d_r;
    sm[0]     = sm[0] | (|(sml27 & lost_mask));
    sum_nxt   = sub1_r ? ({1'b0, big27} - {1'b0, sm}) : ({1'b0, big27} + {1'b0, sm});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      fl1_r  <= fl_nxt;
      s1_r   <= big[31];
      sub1_r <= a[31] ^ b[31];
      is1_r  <= a_inf ? a[31] : b[31];
      mbig_r <= {big[30:23] != 8'd0, big[22:0]};
      msml_r <= {sml[30:23] != 8'd0, sml[22:0]};
      d_r    <= d_nxt;
      eb1_r  <= e_big;
      fl2_r  <= fl1_r;
      s2_r   <= s1_r;
      sub2_r <= sub1_r;
      is2_r  <= is1_r;
      eb2_r  <= eb1_r;
      sum_r  <= sum_nxt;
      res_r  <= res_nxt;
    end
  end

  // Stage 3: normalize (stopping at the subnormal boundary) and round.
  logic [4:0]  lz;
  logic [7:0]  lim, sh;
  logic [26:0] n;
  logic [8:0]  e_res;
  logic        g, st, rnd, ovf;
  logic [7:0]  expf;
  logic [30:0] mag;

  always_comb begin
    lz  = lzc27(sum_r[26:0]);
    lim = eb2_r - 8'd1;
    sh  = 8'd0;
    if (sum_r[27]) begin
      n     = sum_r[27:1];
      n[0]  = n[0] | sum_r[0];
      e_res = {1'b0, eb2_r} + 9'd1;
    end else begin
      sh    = ({3'b000, lz} < lim) ? {3'b000, lz} : lim;
      n     = sum_r[26:0] << sh;
      e_res = {1'b0, eb2_r} - {1'b0, sh};
    end
    ovf  = n[26] && (e_res >= 9'd255);
    expf = n[26] ? e_res[7:0] : 8'd0;
    g    = n[2];
    st   = |n[1:0];
    rnd  = g & (st | n[3]);
    mag  = {expf, n[25:3]} + {30'd0, rnd};
    if (fl2_r.nan) begin
      res_nxt = CANON_QNAN;
    end else if (fl2_r.inf) begin
      res_nxt = {is2_r, EXP_MAX, 23'd0};
    end else if (sum_r == 28'd0) begin
      // An exact cancellation gives +0; two like-signed zeros keep their sign.
      res_nxt = {s2_r & ~sub2_r, 31'd0};
    end else if (ovf) begin
      res_nxt = {s2_r, EXP_MAX, 23'd0};
    end else begin
      res_nxt = {s2_r, mag};
    end
  end

  assign out_valid = v3_r;
  assign result    = res_r;

endmodule

// File: hw/rtl/fisq_chk.sv
// Port-level checker for the fast inverse square root block, bound to the top level.
`include "fast_inverse_sqrt_fp32_defines.svh"

module fisq_chk
  import fisq_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic [31:0] in_value_bits,
  input logic        out_valid,
  input logic        out_stall,
  input logic [31:0] out_result_bits
);

  `FISQ_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_result_bits), "stalled result changed")
  `FISQ_ASSERT_NEXT(a_in_hold, in_valid && in_stall, in_valid && $stable(in_value_bits), "stalled item changed")
  `FISQ_ASSERT_NOW(a_stall_cause, in_stall, out_valid && out_stall, "input stalled without a held result")
  `FISQ_ASSERT_NOW(a_nan_canon, out_valid && out_result_bits[30:23] == EXP_MAX && out_result_bits[22:0] != 23'd0, out_result_bits == CANON_QNAN, "non-canonical NaN result")

endmodule

bind fast_inverse_sqrt_fp32 fisq_chk u_fisq_chk (.*);

// File: tb/fast_inverse_sqrt_fp32_test.sv
// Self-checking testbench for the fast inverse square root pipeline.
module fast_inverse_sqrt_fp32_test
  import fisq_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 20;

  class rsqrt_scoreboard;
    logic [31:0] expected_q[$];
    int          mismatches;

    function bit is_nan(logic [31:0] a);
      return a[30:23] == EXP_MAX && a[22:0] != 0;
    endfunction

    function bit is_inf(logic [31:0] a);
      return a[30:23] == EXP_MAX && a[22:0] == 0;
    endfunction

    function bit is_zero(logic [31:0] a);
      return a[30:0] == 0;
    endfunction

    // Splits an operand into an integer significand and a biased exponent;
    // the value is sig * 2^(exp - 150).
    function void split(logic [31:0] a, output logic [95:0] sig, output int ex);
      if (a[30:23] == 0) begin
        sig = {73'd0, a[22:0]};
        ex  = 1;
      end else begin
        sig = {72'd0, 1'b1, a[22:0]};
        ex  = int'(a[30:23]);
      end
    endfunction

    // Rounds sig * 2^sc to binary32, nearest even, with gradual underflow.
    function logic [31:0] round_pack(bit s, logic [95:0] sig, int sc);
      int          msb;
      int          shift;
      int          q;
      logic [95:0] r;
      logic [95:0] rem;
      logic [95:0] halfway;
      logic [31:0] packed_bits;
      if (sig == 0) return {s, 31'd0};
      msb = 0;
      for (int i = 0; i < 96; i++) if (sig[i]) msb = i;
      shift = msb - 23;
      if (shift < -149 - sc) shift = -149 - sc;
      if (shift <= 0) begin
        r = sig << (-shift);
      end else if (shift > 96) begin
        r = 0;
      end else begin
        r = sig >> shift;
        rem = sig & ((96'd1 << shift) - 96'd1);
        halfway = 96'd1 << (shift - 1);
        if (rem > halfway || (rem == halfway && r[0])) r = r + 1;
      end
      q = sc + shift;
      if (r == (96'd1 << 24)) begin
        r = r >> 1;
        q++;
      end
      if (r == 0) return {s, 31'd0};
      if (q + 150 >= 255) return {s, EXP_MAX, 23'd0};
      // The hidden bit of r carries into the exponent field.
      packed_bits = (32'(q + 149) << 23) + {8'd0, r[23:0]};
      return {s, packed_bits[30:0]};
    endfunction

    function logic [31:0] fp_mul(logic [31:0] a, logic [31:0] b);
      bit          s;
      logic [95:0] ma;
      logic [95:0] mb;
      int          ea;
      int          eb;
      s = a[31] ^ b[31];
      if (is_nan(a) || is_nan(b) || (is_inf(a) && is_zero(b)) || (is_zero(a) && is_inf(b)))
        return CANON_QNAN;
      if (is_inf(a) || is_inf(b)) return {s, EXP_MAX, 23'd0};
      if (is_zero(a) || is_zero(b)) return {s, 31'd0};
      split(a, ma, ea);
      split(b, mb, eb);
      return round_pack(s, ma * mb, ea + eb - 300);
    endfunction

    function logic [31:0] fp_add(logic [31:0] a, logic [31:0] b);
      logic [31:0] tmp;
      logic [95:0] ma;
      logic [95:0] mb;
      logic [95:0] sum;
      int          ea;
      int          eb;
      int          d;
      bit          s;
      if (is_nan(a) || is_nan(b)) return CANON_QNAN;
      if (is_inf(a) && is_inf(b)) return (a[31] != b[31]) ? CANON_QNAN : a;
      if (is_inf(a)) return a;
      if (is_inf(b)) return b;
      if (is_zero(a) && is_zero(b)) return {a[31] & b[31], 31'd0};
      if (is_zero(a)) return b;
      if (is_zero(b)) return a;
      if (a[30:0] < b[30:0]) begin
        tmp = a;
        a = b;
        b = tmp;
      end
      split(a, ma, ea);
      split(b, mb, eb);
      d = ea - eb;
      // A far smaller operand only acts as a sticky bit below the rounding point.
      if (d > 40) begin
        d = 40;
        mb = 1;
      end
      ma = ma << d;
      if (a[31] == b[31]) begin
        sum = ma + mb;
        s = a[31];
      end else if (ma >= mb) begin
        sum = ma - mb;
        s = a[31];
      end else begin
        sum = mb - ma;
        s = b[31];
      end
      if (sum == 0) return 32'd0;
      return round_pack(s, sum, ea - d - 150);
    endfunction

    function logic [31:0] approx_rsqrt(logic [31:0] x);
      logic [31:0] half_x;
      logic [31:0] seed;
      logic [31:0] t;
      logic [31:0] r;
      half_x = fp_mul(x, ONE_HALF);
      seed = MAGIC_SEED - {x[31], x[31:1]};
      t = fp_mul(half_x, seed);
      t = fp_mul(t, seed);
      t = fp_add(THREE_HALVES, {~t[31], t[30:0]});
      r = fp_mul(seed, t);
      return is_nan(r) ? CANON_QNAN : r;
    endfunction

    function void note_operand(logic [31:0] x);
      expected_q = {expected_q, approx_rsqrt(x)};
    endfunction

    function void check_result(logic [31:0] y);
      logic [31:0] want;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", y);
        return;
      end
      want = expected_q.pop_front();
      if (y !== want) begin
        mismatches++;
        if (mismatches <= 10) $display("result_bits mismatch: expected %h, got %h", want, y);
      end
    endfunction
  endclass

  logic        clk = 0;
  logic        rst_n = 0;
  logic        in_valid = 0;
  logic        in_stall;
  logic [31:0] in_value_bits = 0;
  logic        out_valid;
  logic        out_stall = 0;
  logic [31:0] out_result_bits;

  int idle_pct = 0;
  int stall_pct = 0;
  int quiet_cycles = 0;
  rsqrt_scoreboard rsqrt_sb = new();

  fast_inverse_sqrt_fp32 DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_value_bits(in_value_bits),
    .out_valid(out_valid), .out_stall(out_stall), .out_result_bits(out_result_bits)
  );

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  always @(posedge clk) begin
    out_stall <= (stall_pct > 0) && ($urandom_range(99) < stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) rsqrt_sb.note_operand(in_value_bits);
      if (out_valid && !out_stall) rsqrt_sb.check_result(out_result_bits);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // Presents one item and holds it until the block takes it.
  task automatic send_operand(logic [31:0] x);
    while ((idle_pct > 0) && ($urandom_range(99) < idle_pct)) begin
      in_valid <= 0;
      @(posedge clk);
    end
    in_valid <= 1;
    in_value_bits <= x;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  function automatic logic [31:0] random_operand();
    logic [31:0] x;
    x = $urandom;
    case ($urandom_range(7))
      0, 1: x[30:23] = 8'($urandom_range(100, 154));   // typical exponent range, mostly positive
      2: x[30:23] = 0;                                 // subnormal
      3: x[30:23] = EXP_MAX;                           // infinity or NaN
      4: x[30:23] = 8'($urandom_range(250, 254));
      5: x[30:23] = 8'($urandom_range(1, 4));
      default: ;
    endcase
    if ($urandom_range(3) != 0 && x[30:23] != EXP_MAX) x[31] = 0;
    return x;
  endfunction

  logic [31:0] corner_values[22] = '{
    32'h00000000, 32'h80000000, 32'h7f800000, 32'hff800000, 32'h7fc00000,
    32'h7f800001, 32'hffffffff, 32'h7fffffff, 32'h00000001, 32'h80000001,
    32'h007fffff, 32'h00800000, 32'h7f7fffff, 32'hff7fffff, 32'h3f800000,
    32'h40800000, 32'h3e800000, 32'hbf800000, 32'h5f3759df, 32'hbe5f5f5f,
    32'h55555555, 32'haaaaaaaa
  };

  initial begin
    int idle_set[4] = '{0, 66, 0, 30};
    int stall_set[4] = '{0, 0, 66, 30};
    repeat (9) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    foreach (corner_values[i]) send_operand(corner_values[i]);
    for (int p = 0; p < 4; p++) begin
      idle_pct = idle_set[p];
      stall_pct = stall_set[p];
      repeat (300) send_operand(random_operand());
    end
    in_valid <= 0;
    stall_pct = 0;
    while (rsqrt_sb.expected_q.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (rsqrt_sb.mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule

// File: fast_inverse_sqrt_fp32.f
+incdir+hw/rtl
hw/rtl/fisq_pkg.sv
hw/rtl/fisq_mul.sv
hw/rtl/fisq_add.sv
hw/rtl/fast_inverse_sqrt_fp32.sv
hw/rtl/fisq_chk.sv
tb/fast_inverse_sqrt_fp32_test.sv
